[rtl/core/hbfs_pkg.sv]
package hbfs_pkg;

  localparam int NUM_BITS   = 4096;
  localparam int WORD_BITS  = 32;
  localparam int LEAF_WORDS = 128;
  localparam int MID_WORDS  = 4;
  localparam int IDX_W      = 13;
  localparam int LEAF_AW    = 7;
  localparam int BIT_AW     = 5;
  localparam int MID_AW     = 2;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_FILL  = 2'd2;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]       func;
    logic [IDX_W-1:0] index;
    logic             value;
  } in_item_t;

  typedef struct packed {
    logic             bit_at_index;
    logic [IDX_W-1:0] next_set;
    logic [IDX_W-1:0] lowest_set;
    logic [IDX_W-1:0] highest_set;
    logic             index_error;
  } out_item_t;

  // Commands from the sequencer to the leaf store
  typedef struct packed {
    logic                 rd_en;
    logic [LEAF_AW-1:0]   rd_addr;
    logic                 wr_en;
    logic [LEAF_AW-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 clr;
    logic                 clr_fill;
    logic [IDX_W-1:0]     clr_n;
  } leaf_cmd_t;

  // Lowest set bit position; all-zero word gives the top position
  function automatic logic [BIT_AW-1:0] low_bit(input logic [WORD_BITS-1:0] w);
    logic [BIT_AW-1:0] r;
    r = BIT_AW'(WORD_BITS - 1);
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (w[b]) r = BIT_AW'(b);
    end
    return r;
  endfunction

  // Highest set bit position; all-zero word gives zero
  function automatic logic [BIT_AW-1:0] high_bit(input logic [WORD_BITS-1:0] w);
    logic [BIT_AW-1:0] r;
    r = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (w[b]) r = BIT_AW'(b);
    end
    return r;
  endfunction

endpackage

[rtl/core/hierarchical_bitmap_find_set.sv]
// Hierarchical bitmap of 4096 bits: 128 leaf words in a one-port-read,
// one-port-write memory, four middle summary words and one top summary word
// in registers. An item is taken when start is high and busy is low; its
// result appears on out_item for exactly one cycle with out_valid high and
// must be taken then. Busy drops in the cycle the result is shown, so the
// next item can be taken at the edge that takes the result. The leaf memory
// is read once per step for the word at the index, the lowest and highest
// occupied words and the next occupied word, plus one write step and one
// re-read step for a bit write and one re-read step after a fill. A fill or
// a write of bit_count takes effect at once: the leaf valid bits are
// cleared and unwritten words read as the fill pattern.
module hierarchical_bitmap_find_set (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  hbfs_pkg::in_item_t             in_item,
  output logic                           out_valid,
  output hbfs_pkg::out_item_t            out_item,
  input  logic                           cfg_we,
  input  logic [hbfs_pkg::IDX_W-1:0]     cfg_wdata
);
  import hbfs_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_WWR  = 7'b0000010,
    ST_QI   = 7'b0000100,
    ST_QL   = 7'b0001000,
    ST_QH   = 7'b0010000,
    ST_QN   = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]     bit_count_r;
  logic [IDX_W-1:0]     n_used;
  logic [WORD_BITS-1:0] mid_r [MID_WORDS];
  logic [WORD_BITS-1:0] mid_nxt [MID_WORDS];
  logic [MID_WORDS-1:0] top_r, top_nxt;

  logic [IDX_W-2:0]     pos_r;
  logic                 value_r;
  logic                 valid_r;
  logic [WORD_BITS-1:0] wi_r, wl_r, wh_r;
  logic [LEAF_AW-1:0]   lo_leaf_r, hi_leaf_r, j_r;
  logic                 j_found_r;
  logic                 out_valid_r;
  out_item_t            out_item_r;

  leaf_cmd_t            cmd;
  logic [WORD_BITS-1:0] rd_word;

  logic                 accept;
  logic                 in_valid;
  logic [IDX_W-1:0]     in_pos;
  logic [7:0]           fill_leaves;

  logic [LEAF_AW-1:0]   i_cur;
  logic [BIT_AW-1:0]    b_cur;
  logic [MID_AW-1:0]    mi_cur;
  logic [WORD_BITS-1:0] bit_mask;
  logic [WORD_BITS-1:0] new_word;
  logic [WORD_BITS-1:0] new_mid;

  logic [BIT_AW-1:0]    top_lo_b, top_hi_b;
  logic [MID_AW-1:0]    top_lo, top_hi;
  logic [BIT_AW-1:0]    mid_lo_b, mid_hi_b;

  logic [WORD_BITS-1:0] mid_gt;
  logic [MID_WORDS-1:0] top_gt;
  logic [BIT_AW-1:0]    mid_gt_b, top_gt_b, mid_j_b;
  logic [MID_AW-1:0]    top_gt_m;
  logic [LEAF_AW-1:0]   j_cur;

  logic [WORD_BITS-1:0] wi_masked;
  out_item_t            res;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Clamp the bit count to the store size
  assign n_used   = (bit_count_r > IDX_W'(NUM_BITS)) ? IDX_W'(NUM_BITS) : bit_count_r;
  assign in_pos   = in_item.index - IDX_W'(1);
  assign in_valid = (in_item.index != '0) && (in_item.index <= n_used);
  assign fill_leaves = 8'((14'(n_used) + 14'(WORD_BITS - 1)) >> BIT_AW);

  assign i_cur    = pos_r[IDX_W-2:BIT_AW];
  assign b_cur    = pos_r[BIT_AW-1:0];
  assign mi_cur   = i_cur[LEAF_AW-1:BIT_AW];
  assign bit_mask = WORD_BITS'(1) << b_cur;
  assign new_word = value_r ? (rd_word | bit_mask) : (rd_word & ~bit_mask);
  assign new_mid  = mid_r[mi_cur] & ~(WORD_BITS'(1) << i_cur[BIT_AW-1:0]);

  // Lowest and highest occupied leaf from the summaries
  assign top_lo_b = low_bit(WORD_BITS'(top_r));
  assign top_hi_b = high_bit(WORD_BITS'(top_r));
  assign top_lo   = top_lo_b[MID_AW-1:0];
  assign top_hi   = top_hi_b[MID_AW-1:0];
  assign mid_lo_b = low_bit(mid_r[top_lo]);
  assign mid_hi_b = high_bit(mid_r[top_hi]);

  // Next occupied leaf after the indexed one
  assign mid_gt   = mid_r[mi_cur] & ~((WORD_BITS'(2) << i_cur[BIT_AW-1:0]) - WORD_BITS'(1));
  assign top_gt   = top_r & ~((MID_WORDS'(2) << mi_cur) - MID_WORDS'(1));
  assign mid_gt_b = low_bit(mid_gt);
  assign top_gt_b = low_bit(WORD_BITS'(top_gt));
  assign top_gt_m = top_gt_b[MID_AW-1:0];
  assign mid_j_b  = low_bit(mid_r[top_gt_m]);
  assign j_cur    = (mid_gt != '0) ? {mi_cur, mid_gt_b} : {top_gt_m, mid_j_b};

  // Leaf store commands
  always_comb begin
    cmd          = '0;
    cmd.clr_n    = n_used;
    cmd.wr_addr  = i_cur;
    cmd.wr_data  = new_word;
    case (state_r)
      ST_IDLE: begin
        cmd.rd_en    = accept;
        cmd.rd_addr  = in_pos[IDX_W-2:BIT_AW];
        cmd.clr      = cfg_we || (accept && in_item.func == FUNC_FILL);
        cmd.clr_fill = !cfg_we && in_item.value;
      end
      ST_WWR:  cmd.wr_en = 1'b1;
      ST_QI: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = i_cur;
      end
      ST_QL: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = {top_lo, mid_lo_b};
      end
      ST_QH: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = {top_hi, mid_hi_b};
      end
      ST_QN: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = j_cur;
      end
      default: cmd.rd_en = 1'b0;
    endcase
  end

  hbfs_leaf_mem u_leaf (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_word (rd_word)
  );

  // Summary updates: fill, clear and single bit write
  always_comb begin
    for (int m = 0; m < MID_WORDS; m++) mid_nxt[m] = mid_r[m];
    top_nxt = top_r;
    if (state_r == ST_IDLE && cfg_we) begin
      for (int m = 0; m < MID_WORDS; m++) mid_nxt[m] = '0;
      top_nxt = '0;
    end else if (accept && in_item.func == FUNC_FILL) begin
      for (int m = 0; m < MID_WORDS; m++) begin
        for (int k = 0; k < WORD_BITS; k++) begin
          mid_nxt[m][k] = in_item.value && (8'(m * WORD_BITS + k) < fill_leaves);
        end
        top_nxt[m] = in_item.value && (8'(m * WORD_BITS) < fill_leaves);
      end
    end else if (state_r == ST_WWR) begin
      if (value_r) begin
        mid_nxt[mi_cur][i_cur[BIT_AW-1:0]] = 1'b1;
        top_nxt[mi_cur] = 1'b1;
      end else if (new_word == '0) begin
        mid_nxt[mi_cur] = new_mid;
        if (new_mid == '0) top_nxt[mi_cur] = 1'b0;
      end
    end
  end

  // Sequencer: write, then read index, lowest, highest and next words
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.func == FUNC_WRITE && in_valid) state_nxt = ST_WWR;
          else if (in_item.func == FUNC_FILL) state_nxt = ST_QI;
          else state_nxt = ST_QL;
        end
      end
      ST_WWR:  state_nxt = ST_QI;
      ST_QI:   state_nxt = ST_QL;
      ST_QL:   state_nxt = ST_QH;
      ST_QH:   state_nxt = ST_QN;
      ST_QN:   state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result assembly
  assign wi_masked = wi_r & ({WORD_BITS{1'b1}} << b_cur);
  always_comb begin
    res              = '0;
    res.index_error  = !valid_r;
    res.bit_at_index = valid_r && wi_r[b_cur];
    if (valid_r) begin
      if (wi_masked != '0) begin
        res.next_set = IDX_W'({i_cur, low_bit(wi_masked)}) + IDX_W'(1);
      end else if (j_found_r) begin
        res.next_set = IDX_W'({j_r, low_bit(rd_word)}) + IDX_W'(1);
      end
    end
    if (top_r != '0) begin
      res.lowest_set  = IDX_W'({lo_leaf_r, low_bit(wl_r)}) + IDX_W'(1);
      res.highest_set = IDX_W'({hi_leaf_r, high_bit(wh_r)}) + IDX_W'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bit_count_r <= IDX_W'(NUM_BITS);
      top_r       <= '0;
      out_valid_r <= 1'b0;
      for (int m = 0; m < MID_WORDS; m++) mid_r[m] <= '0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      out_valid_r <= (state_r == ST_DONE);
      for (int m = 0; m < MID_WORDS; m++) mid_r[m] <= mid_nxt[m];
      if (state_r == ST_IDLE && cfg_we) bit_count_r <= cfg_wdata;
    end
  end

  // Item and captured word registers
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r   <= in_pos[IDX_W-2:0];
      value_r <= in_item.value;
      valid_r <= in_valid;
    end
    if (state_r == ST_QL) begin
      wi_r      <= rd_word;
      lo_leaf_r <= {top_lo, mid_lo_b};
    end
    if (state_r == ST_QH) begin
      wl_r      <= rd_word;
      hi_leaf_r <= {top_hi, mid_hi_b};
    end
    if (state_r == ST_QN) begin
      wh_r      <= rd_word;
      j_r       <= j_cur;
      j_found_r <= (mid_gt != '0) || (top_gt != '0);
    end
    if (state_r == ST_DONE) begin
      out_item_r <= res;
    end
  end

endmodule

[rtl/core/hbfs_leaf_mem.sv]
module hbfs_leaf_mem (
  input  logic                             clk,
  input  logic                             rst_n,
  input  hbfs_pkg::leaf_cmd_t              cmd,
  output logic [hbfs_pkg::WORD_BITS-1:0]   rd_word
);
  import hbfs_pkg::*;

  logic [WORD_BITS-1:0] mem [LEAF_WORDS];
  logic [LEAF_WORDS-1:0] vld_r;
  logic                 fill_val_r;
  logic [IDX_W-1:0]     fill_n_r;
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_hit_r;
  logic [LEAF_AW-1:0]   rd_addr_r;
  logic [WORD_BITS-1:0] fill_word;
  logic [7:0]           full_words;

  // Data array: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr];
      rd_addr_r <= cmd.rd_addr;
    end
  end

  // Valid bits: an entry not written since the last clear reads as the fill pattern
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      fill_val_r <= 1'b0;
      fill_n_r   <= '0;
      rd_hit_r   <= 1'b0;
    end else begin
      if (cmd.rd_en) begin
        rd_hit_r <= vld_r[cmd.rd_addr];
      end
      if (cmd.clr) begin
        vld_r      <= '0;
        fill_val_r <= cmd.clr_fill;
        fill_n_r   <= cmd.clr_n;
      end else if (cmd.wr_en) begin
        vld_r[cmd.wr_addr] <= 1'b1;
      end
    end
  end

  // Fill pattern: bits below fill_n set
  assign full_words = fill_n_r[IDX_W-1:BIT_AW];
  always_comb begin
    fill_word = '0;
    if (fill_val_r) begin
      if ({1'b0, rd_addr_r} < full_words) begin
        fill_word = '1;
      end else if ({1'b0, rd_addr_r} == full_words) begin
        fill_word = (WORD_BITS'(1) << fill_n_r[BIT_AW-1:0]) - WORD_BITS'(1);
      end
    end
  end

  assign rd_word = rd_hit_r ? rd_data_r : fill_word;

endmodule
